// ===== hw/rtl/ddsl_pkg.sv =====
// Shared types, codes and fixed widths for the differential drive command unit.
// No dependencies; the lane, merge, top and test files refer to this package by scoped names.
package ddsl_pkg;

	// Stored wheel speed stays within +/- 32767, so 16 bits hold it whatever the port width.
	localparam int NOW_W  = 16;
	localparam int LIM_W  = 15;
	localparam int DREG_W = 10;
	localparam int MAG_W  = 15;
	localparam int PROD_W = DREG_W + MAG_W;
	localparam int QUO_W  = DREG_W + 1;
	localparam int CNT_W  = 4;

	typedef enum logic [1:0] {
		KIND_STRAIGHT = 2'd0,
		KIND_STOP     = 2'd1,
		KIND_TURN     = 2'd2,
		KIND_BAD      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_SPEED_LIMIT = 2'd0,
		CFG_STEP_LIMIT  = 2'd1,
		CFG_FULL_SCALE  = 2'd2,
		CFG_DUTY_STEPS  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		LN_IDLE,
		LN_RAMP,
		LN_MUL,
		LN_CHK,
		LN_DIV,
		LN_FIN
	} lane_st_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_PUSH
	} top_st_t;

	typedef struct packed {
		logic [LIM_W-1:0]  speed_limit;
		logic [LIM_W-1:0]  step_limit;
		logic [LIM_W-1:0]  full_scale;
		logic [DREG_W-1:0] duty_steps;
	} cfg_t;

	typedef struct packed {
		logic hold;
		logic zero;
		logic neg;
	} lane_cmd_t;

	typedef struct packed {
		logic signed [NOW_W-1:0] speed;
		logic [DREG_W-1:0]       duty;
	} lane_res_t;

endpackage

// ===== hw/rtl/ddsl_ifs.sv =====
// Valid/ready channel interfaces for drive commands and motor results.
// Widths follow the top level's SPEED_BITS and DUTY_BITS parameters.
interface ddsl_cmd_if #(
	parameter int SPEED_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic                         dir_right;
	logic signed [SPEED_BITS-1:0] speed_right;
	logic signed [SPEED_BITS-1:0] speed_left;

	modport source (output valid, kind, dir_right, speed_right, speed_left, input ready);
	modport sink (input valid, kind, dir_right, speed_right, speed_left, output ready);
endinterface

interface ddsl_res_if #(
	parameter int SPEED_BITS = 16,
	parameter int DUTY_BITS  = 10
);
	logic                         valid;
	logic                         ready;
	logic signed [SPEED_BITS-1:0] right_speed;
	logic signed [SPEED_BITS-1:0] left_speed;
	logic [DUTY_BITS-1:0]         right_duty;
	logic [DUTY_BITS-1:0]         left_duty;
	logic [3:0]                   bridge_pins;
	logic                         bad_command;

	modport source (output valid, right_speed, left_speed, right_duty, left_duty,
		bridge_pins, bad_command, input ready);
	modport sink (input valid, right_speed, left_speed, right_duty, left_duty,
		bridge_pins, bad_command, output ready);
endinterface

// ===== hw/rtl/ddsl_lane.sv =====
// One wheel lane: target clamp, slew-limited ramp, duty product and iterative divide.
// Depends on ddsl_pkg for config, command and result types.
module ddsl_lane #(
	parameter int SPEED_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  ddsl_pkg::lane_cmd_t          cmd,
	input  logic signed [SPEED_BITS-1:0] speed_req,
	input  ddsl_pkg::cfg_t               cfg,
	output logic                         done,
	output ddsl_pkg::lane_res_t          res
);
	localparam int TW = (SPEED_BITS > 15) ? SPEED_BITS + 1 : 17;
	localparam int NW = ddsl_pkg::NOW_W;
	localparam int PW = ddsl_pkg::PROD_W;
	localparam int QW = ddsl_pkg::QUO_W;

	ddsl_pkg::lane_st_t st_q, st_d;

	logic signed [NW-1:0]       tgt_q, now_q;
	logic                       hold_q;
	logic [PW-1:0]              prod_q, rem_q, dsh_q;
	logic [QW-1:0]              quo_q;
	logic [ddsl_pkg::CNT_W-1:0] cnt_q;

	logic signed [TW-1:0] req_w, sgn_w, lim_w, clamp_w;
	logic signed [NW:0]   diff_w, step_w, up_w, dn_w;
	logic signed [NW-1:0] ramp_w, abs_w;
	logic [PW:0]          ovf_lim_w;
	logic [QW-1:0]        dsteps_w;

	// Signed target, zero on stop, else clamped to +/- speed_limit at full precision.
	always_comb begin
		req_w = TW'(speed_req);
		sgn_w = cmd.neg ? -req_w : req_w;
		lim_w = signed'(TW'(cfg.speed_limit));
		if (cmd.zero) begin
			clamp_w = '0;
		end else if (sgn_w > lim_w) begin
			clamp_w = lim_w;
		end else if (sgn_w < -lim_w) begin
			clamp_w = -lim_w;
		end else begin
			clamp_w = sgn_w;
		end
	end

	// Move toward the target by at most step_limit.
	always_comb begin
		diff_w = (NW+1)'(tgt_q) - (NW+1)'(now_q);
		step_w = signed'((NW+1)'(cfg.step_limit));
		up_w   = (NW+1)'(now_q) + step_w;
		dn_w   = (NW+1)'(now_q) - step_w;
		if (diff_w > step_w) begin
			ramp_w = up_w[NW-1:0];
		end else if (diff_w < -step_w) begin
			ramp_w = dn_w[NW-1:0];
		end else begin
			ramp_w = tgt_q;
		end
		abs_w = now_q[NW-1] ? -now_q : now_q;
	end

	// Any quotient at or beyond 2^QW saturates at duty_steps anyway.
	assign ovf_lim_w = (PW+1)'({cfg.full_scale, QW'(0)});
	assign dsteps_w  = QW'(cfg.duty_steps);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ddsl_pkg::LN_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		done = 1'b0;
		case (st_q)
			ddsl_pkg::LN_IDLE: begin
				if (start) st_d = ddsl_pkg::LN_RAMP;
			end
			ddsl_pkg::LN_RAMP: st_d = ddsl_pkg::LN_MUL;
			ddsl_pkg::LN_MUL:  st_d = ddsl_pkg::LN_CHK;
			ddsl_pkg::LN_CHK: begin
				if (prod_q == '0 || {1'b0, prod_q} >= ovf_lim_w) begin
					st_d = ddsl_pkg::LN_FIN;
				end else begin
					st_d = ddsl_pkg::LN_DIV;
				end
			end
			ddsl_pkg::LN_DIV: begin
				if (cnt_q == '0) st_d = ddsl_pkg::LN_FIN;
			end
			ddsl_pkg::LN_FIN: begin
				done = 1'b1;
				st_d = ddsl_pkg::LN_IDLE;
			end
			default: st_d = ddsl_pkg::LN_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (st_q == ddsl_pkg::LN_RAMP && !hold_q) begin
			now_q <= ramp_w;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ddsl_pkg::LN_IDLE: begin
				if (start) begin
					tgt_q  <= clamp_w[NW-1:0];
					hold_q <= cmd.hold;
				end
			end
			ddsl_pkg::LN_MUL: begin
				prod_q <= PW'(cfg.duty_steps) * PW'(abs_w[ddsl_pkg::MAG_W-1:0]);
			end
			ddsl_pkg::LN_CHK: begin
				rem_q <= prod_q;
				dsh_q <= PW'(cfg.full_scale) << (QW - 1);
				cnt_q <= ddsl_pkg::CNT_W'(QW - 1);
				if (prod_q == '0) begin
					quo_q <= '0;
				end else if ({1'b0, prod_q} >= ovf_lim_w) begin
					quo_q <= '1;
				end else begin
					quo_q <= '0;
				end
			end
			ddsl_pkg::LN_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.speed = now_q;
		res.duty  = (quo_q > dsteps_w) ? cfg.duty_steps : quo_q[ddsl_pkg::DREG_W-1:0];
	end

endmodule

// ===== hw/rtl/ddsl_merge.sv =====
// Merges both lane results into one beat: pins, flag, port widths, output register.
// Depends on ddsl_pkg and the ddsl_res_if interface.
module ddsl_merge #(
	parameter int SPEED_BITS = 16,
	parameter int DUTY_BITS  = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic                bad,
	input  ddsl_pkg::lane_res_t r_res,
	input  ddsl_pkg::lane_res_t l_res,
	output logic                free,
	ddsl_res_if.source          res
);
	logic                         vld_q;
	logic signed [SPEED_BITS-1:0] r_spd_q, l_spd_q;
	logic [DUTY_BITS-1:0]         r_duty_q, l_duty_q;
	logic [3:0]                   pins_q;
	logic                         bad_q;

	logic signed [32:0] r_ext, l_ext;
	logic [15:0]        r_dext, l_dext;
	logic               r_pos, l_neg;

	always_comb begin
		r_ext  = 33'(signed'(r_res.speed));
		l_ext  = 33'(signed'(l_res.speed));
		r_dext = 16'(r_res.duty);
		l_dext = 16'(l_res.duty);
		r_pos  = !r_res.speed[ddsl_pkg::NOW_W-1] && (r_res.speed != '0);
		l_neg  = l_res.speed[ddsl_pkg::NOW_W-1];
	end

	assign free = !vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (res.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r_spd_q  <= r_ext[SPEED_BITS-1:0];
			l_spd_q  <= l_ext[SPEED_BITS-1:0];
			r_duty_q <= r_dext[DUTY_BITS-1:0];
			l_duty_q <= l_dext[DUTY_BITS-1:0];
			pins_q   <= {l_neg, !l_neg, !r_pos, r_pos};
			bad_q    <= bad;
		end
	end

	always_comb begin
		res.valid       = vld_q;
		res.right_speed = r_spd_q;
		res.left_speed  = l_spd_q;
		res.right_duty  = r_duty_q;
		res.left_duty   = l_duty_q;
		res.bridge_pins = pins_q;
		res.bad_command = bad_q;
	end

endmodule

// ===== hw/rtl/diff_drive_slew_limited_motor_cmd_unit.sv =====
// Top level of the differential drive command unit: config registers, control, two lanes.
// Depends on ddsl_pkg, ddsl_ifs, ddsl_lane and ddsl_merge.
//
//  channel | dir | handshake          | beat contents
//  --------+-----+--------------------+------------------------------------------------
//  cmd     | in  | cmd.valid/ready    | kind, dir_right, speed_right, speed_left
//  res     | out | res.valid/ready    | right/left speed, right/left duty, pins, flag
//  cfg     | in  | cfg_we (no wait)   | cfg_idx selects register, cfg_data value
//
// From accept to result valid a command passes the lane's ramp, multiply, range check,
// restoring divider (eleven quotient bits, one quotient bit per cycle) and finish states,
// then the push state, which waits until the output is free, and the output load.
// A lane whose duty is zero or saturated skips the divider. Both wheels run in their own
// lane at once. The next command is taken once the result is in the output register,
// even while that result still waits on res.ready. Reset clears the wheel speeds and
// loads the register defaults; no clearing pass.
module diff_drive_slew_limited_motor_cmd_unit #(
	parameter int SPEED_BITS = 16,
	parameter int DUTY_BITS  = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ddsl_cmd_if.sink                    cmd,
	ddsl_res_if.source                  res,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_idx,
	input  logic [ddsl_pkg::LIM_W-1:0]  cfg_data
);
	ddsl_pkg::cfg_t      cfg_q;
	ddsl_pkg::top_st_t   st_q, st_d;
	ddsl_pkg::lane_cmd_t r_cmd, l_cmd;
	ddsl_pkg::lane_res_t r_res, l_res;
	ddsl_pkg::kind_t     kind_w;

	logic bad_q;
	logic r_fin_q, l_fin_q;
	logic start, r_done, l_done, load, free;

	// Configuration registers; the user must write them only while idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_limit <= ddsl_pkg::LIM_W'(1600);
			cfg_q.step_limit  <= ddsl_pkg::LIM_W'(160);
			cfg_q.full_scale  <= ddsl_pkg::LIM_W'(3200);
			cfg_q.duty_steps  <= ddsl_pkg::DREG_W'(100);
		end else if (cfg_we) begin
			case (ddsl_pkg::cfg_idx_t'(cfg_idx))
				ddsl_pkg::CFG_SPEED_LIMIT: cfg_q.speed_limit <= cfg_data;
				ddsl_pkg::CFG_STEP_LIMIT:  cfg_q.step_limit  <= cfg_data;
				ddsl_pkg::CFG_FULL_SCALE:  cfg_q.full_scale  <= cfg_data;
				ddsl_pkg::CFG_DUTY_STEPS:  cfg_q.duty_steps  <= cfg_data[ddsl_pkg::DREG_W-1:0];
				default: ;
			endcase
		end
	end

	// Decode the command into per-wheel sign, zero and hold controls.
	// Straight: right follows the direction bit, left runs mirrored.
	// Turn on the spot: both wheels take the inverted direction sign.
	always_comb begin
		kind_w     = ddsl_pkg::kind_t'(cmd.kind);
		r_cmd.hold = (kind_w == ddsl_pkg::KIND_BAD);
		r_cmd.zero = (kind_w == ddsl_pkg::KIND_STOP);
		r_cmd.neg  = (kind_w == ddsl_pkg::KIND_STRAIGHT) ? !cmd.dir_right : cmd.dir_right;
		l_cmd.hold = r_cmd.hold;
		l_cmd.zero = r_cmd.zero;
		l_cmd.neg  = cmd.dir_right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ddsl_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Lanes may finish on different cycles; hold each done until the next command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_fin_q <= 1'b0;
			l_fin_q <= 1'b0;
		end else if (start) begin
			r_fin_q <= 1'b0;
			l_fin_q <= 1'b0;
		end else begin
			if (r_done) r_fin_q <= 1'b1;
			if (l_done) l_fin_q <= 1'b1;
		end
	end

	// Control: take a beat when idle, wait for both lanes, push into the output register.
	always_comb begin
		st_d      = st_q;
		cmd.ready = 1'b0;
		start     = 1'b0;
		load      = 1'b0;
		case (st_q)
			ddsl_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					start = 1'b1;
					st_d  = ddsl_pkg::ST_BUSY;
				end
			end
			ddsl_pkg::ST_BUSY: begin
				if ((r_done || r_fin_q) && (l_done || l_fin_q)) st_d = ddsl_pkg::ST_PUSH;
			end
			ddsl_pkg::ST_PUSH: begin
				// Hold here while the previous result still sits unread.
				if (free) begin
					load = 1'b1;
					st_d = ddsl_pkg::ST_IDLE;
				end
			end
			default: st_d = ddsl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) bad_q <= (kind_w == ddsl_pkg::KIND_BAD);
	end

	ddsl_lane #(
		.SPEED_BITS(SPEED_BITS)
	) u_lane_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (r_cmd),
		.speed_req (cmd.speed_right),
		.cfg       (cfg_q),
		.done      (r_done),
		.res       (r_res)
	);

	ddsl_lane #(
		.SPEED_BITS(SPEED_BITS)
	) u_lane_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (l_cmd),
		.speed_req (cmd.speed_left),
		.cfg       (cfg_q),
		.done      (l_done),
		.res       (l_res)
	);

	ddsl_merge #(
		.SPEED_BITS(SPEED_BITS),
		.DUTY_BITS (DUTY_BITS)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.bad    (bad_q),
		.r_res  (r_res),
		.l_res  (l_res),
		.free   (free),
		.res    (res)
	);

endmodule

// ===== hw/rtl/ddsl_checker.sv =====
// Port-level checks for the differential drive command unit, bound to the top level.
// Depends only on the top level's ports.
module ddsl_checker #(
	parameter int SPEED_BITS = 16,
	parameter int DUTY_BITS  = 10
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cmd_valid,
	input logic                  cmd_ready,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic [SPEED_BITS-1:0] res_right_speed,
	input logic [SPEED_BITS-1:0] res_left_speed,
	input logic [DUTY_BITS-1:0]  res_right_duty,
	input logic [DUTY_BITS-1:0]  res_left_duty,
	input logic [3:0]            res_bridge_pins,
	input logic                  res_bad_command
);

	// A stalled result beat stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_right_speed) && $stable(res_left_speed)
			&& $stable(res_right_duty) && $stable(res_left_duty)
			&& $stable(res_bridge_pins) && $stable(res_bad_command))
		else $error("result payload changed while stalled");

	// Each pin pair of the bridge is driven in complement.
	a_pins: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_bridge_pins[1] == !res_bridge_pins[0])
			&& (res_bridge_pins[2] == !res_bridge_pins[3]))
		else $error("bridge pin pair not complementary");

	// One command at a time: the unit is busy right after taking a beat.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous one in flight");

endmodule

bind diff_drive_slew_limited_motor_cmd_unit ddsl_checker #(
	.SPEED_BITS(SPEED_BITS),
	.DUTY_BITS (DUTY_BITS)
) u_ddsl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_right_speed (res.right_speed),
	.res_left_speed  (res.left_speed),
	.res_right_duty  (res.right_duty),
	.res_left_duty   (res.left_duty),
	.res_bridge_pins (res.bridge_pins),
	.res_bad_command (res.bad_command)
);

// ===== test/diff_drive_slew_limited_motor_cmd_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the differential drive command unit: a directed command table,
// then random phases under changing register settings, scored by an in-bench predictor or typed results.
// Depends on ddsl_pkg and on the ddsl_cmd_if / ddsl_res_if channel interfaces of the RTL.
module diff_drive_slew_limited_motor_cmd_unit_test;

	localparam int SPD_W       = 16;
	localparam int DTY_W       = 10;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYC   = 10;
	// No beat on either channel for this long means the block is stuck. The slowest
	// correct beat is a source gap plus the lane work plus a sink stall.
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASES      = 8;
	localparam int PHASE_CMDS  = 160;

	// One motor result as the block should present it.
	typedef struct {
		logic signed [SPD_W-1:0] right_speed;
		logic signed [SPD_W-1:0] left_speed;
		logic [DTY_W-1:0]        right_duty;
		logic [DTY_W-1:0]        left_duty;
		logic [3:0]              pins;
		logic                    bad;
	} motor_res_t;

	// One row of the directed table: either a register write or a drive command.
	// Rows with known set carry a hand-typed result instead of the predicted one.
	typedef struct {
		bit                      is_write;
		ddsl_pkg::cfg_idx_t      reg_idx;
		int unsigned             reg_val;
		ddsl_pkg::kind_t         kind;
		bit                      dir;
		logic signed [SPD_W-1:0] sr;
		logic signed [SPD_W-1:0] sl;
		bit                      known;
		motor_res_t              want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [ddsl_pkg::LIM_W-1:0] cfg_data;

	ddsl_cmd_if #(.SPEED_BITS(SPD_W)) cmd_ch();
	ddsl_res_if #(.SPEED_BITS(SPD_W), .DUTY_BITS(DTY_W)) res_ch();

	diff_drive_slew_limited_motor_cmd_unit #(
		.SPEED_BITS(SPD_W),
		.DUTY_BITS(DTY_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Predictor copy of the registers and of the two wheel speeds.
	int unsigned lim_speed;
	int unsigned lim_step;
	int unsigned scale_speed;
	int unsigned duty_full;
	int right_now;
	int left_now;

	motor_res_t pending_motor[$];   // results still owed by the block, oldest first
	plan_row_t  plan[$];
	motor_res_t blank_res;
	motor_res_t head_res;

	int  mismatch_count = 0;
	int  result_count = 0;
	int  quiet_cycles = 0;
	bit  feed_calm = 1'b0;          // command side sends back to back
	bit  sink_calm = 1'b0;          // result side never stalls

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Clamp the target to +/- speed limit, then move toward it by at most one step.
	function automatic int slew(int target, int now);
		int lim;
		int stp;
		int diff;
		lim = int'(lim_speed);
		stp = int'(lim_step);
		if (target > lim)
			target = lim;
		if (target < -lim)
			target = -lim;
		diff = target - now;
		if (diff > stp)
			return now + stp;
		if (diff < -stp)
			return now - stp;
		return target;
	endfunction

	// Duty = duty_steps * |speed| / full_scale, truncated and saturated at duty_steps.
	// A zero full scale saturates straight to full duty for any nonzero speed.
	function automatic logic [DTY_W-1:0] duty_of(int speed);
		longint mag;
		longint d;
		mag = (speed < 0) ? -speed : speed;
		if (scale_speed == 0)
			d = (mag != 0) ? longint'(duty_full) : 0;
		else
			d = (longint'(duty_full) * mag) / longint'(scale_speed);
		if (d > longint'(duty_full))
			d = duty_full;
		return d[DTY_W-1:0];
	endfunction

	// Advance the wheel speeds by one command and form the result it yields.
	function automatic motor_res_t motor_step(ddsl_pkg::kind_t kind, bit dir,
			logic signed [SPD_W-1:0] sr, logic signed [SPD_W-1:0] sl);
		motor_res_t r;
		int sgn;
		r.bad = 1'b0;
		case (kind)
			ddsl_pkg::KIND_STRAIGHT: begin
				// Right wheel follows the direction bit, left wheel is mirrored.
				sgn = dir ? 1 : -1;
				right_now = slew(sgn * int'(sr), right_now);
				left_now  = slew(-sgn * int'(sl), left_now);
			end
			ddsl_pkg::KIND_STOP: begin
				right_now = slew(0, right_now);
				left_now  = slew(0, left_now);
			end
			ddsl_pkg::KIND_TURN: begin
				sgn = dir ? -1 : 1;
				right_now = slew(sgn * int'(sr), right_now);
				left_now  = slew(sgn * int'(sl), left_now);
			end
			default: begin
				// Unhandled kind: hold both speeds, raise the flag.
				r.bad = 1'b1;
			end
		endcase
		r.right_speed = right_now[SPD_W-1:0];
		r.left_speed  = left_now[SPD_W-1:0];
		r.right_duty  = duty_of(right_now);
		r.left_duty   = duty_of(left_now);
		// bit0 r1, bit1 r2, bit2 l1, bit3 l2
		r.pins = {left_now < 0, !(left_now < 0), !(right_now > 0), right_now > 0};
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed table construction
	// ------------------------------------------------------------------

	task automatic plan_write(ddsl_pkg::cfg_idx_t idx, int unsigned val);
		plan_row_t row;
		row.is_write = 1'b1;
		row.reg_idx  = idx;
		row.reg_val  = val;
		plan.push_back(row);
	endtask

	task automatic plan_cmd(ddsl_pkg::kind_t kind, bit dir, int sr, int sl);
		plan_row_t row;
		row.is_write = 1'b0;
		row.kind     = kind;
		row.dir      = dir;
		row.sr       = sr[SPD_W-1:0];
		row.sl       = sl[SPD_W-1:0];
		row.known    = 1'b0;
		plan.push_back(row);
	endtask

	task automatic plan_known(ddsl_pkg::kind_t kind, bit dir, int sr, int sl,
			int rs, int ls, int rd, int ld, int pins, int bad);
		plan_cmd(kind, dir, sr, sl);
		plan[$].known            = 1'b1;
		plan[$].want.right_speed = rs[SPD_W-1:0];
		plan[$].want.left_speed  = ls[SPD_W-1:0];
		plan[$].want.right_duty  = rd[DTY_W-1:0];
		plan[$].want.left_duty   = ld[DTY_W-1:0];
		plan[$].want.pins        = pins[3:0];
		plan[$].want.bad         = bad[0];
	endtask

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Called at a falling edge, returns at the falling edge after the beat.
	// Valid is left high on return; the next call either presents a new beat
	// in that same step or drops valid for its gap.
	task automatic send_cmd(ddsl_pkg::kind_t kind, bit dir, logic signed [SPD_W-1:0] sr,
			logic signed [SPD_W-1:0] sl, bit known, motor_res_t want);
		int gap;
		motor_res_t pred;
		gap = feed_calm ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.kind        <= kind;
		cmd_ch.dir_right   <= dir;
		cmd_ch.speed_right <= sr;
		cmd_ch.speed_left  <= sl;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		// Beat taken: step the predictor even when the row has a typed result.
		pred = motor_step(kind, dir, sr, sl);
		if (known)
			pending_motor.push_back(want);
		else
			pending_motor.push_back(pred);
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed result has come back, plus a margin.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (pending_motor.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register write while the block is idle; mirror it into the predictor.
	task automatic write_reg(ddsl_pkg::cfg_idx_t idx, int unsigned val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val[ddsl_pkg::LIM_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			ddsl_pkg::CFG_SPEED_LIMIT: lim_speed   = val & 32'h7FFF;
			ddsl_pkg::CFG_STEP_LIMIT:  lim_step    = val & 32'h7FFF;
			ddsl_pkg::CFG_FULL_SCALE:  scale_speed = val & 32'h7FFF;
			ddsl_pkg::CFG_DUTY_STEPS:  duty_full   = val & 32'h3FF;
			default: ;
		endcase
	endtask

	// Register value: often an extreme, often a typical small value, else anything.
	function automatic int unsigned pick_reg(int unsigned lo, int unsigned hi,
			int unsigned typical);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			2, 3: return $urandom_range(lo, typical);
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	// Requested speed: full random, moderate, extremes, or near the current limit.
	function automatic logic signed [SPD_W-1:0] pick_speed();
		int v;
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			v = $urandom_range(0, 65535);
		else if (r < 7)
			v = int'($urandom_range(0, 4000)) - 2000;
		else if (r == 7) begin
			case ($urandom_range(0, 4))
				0: v = -32768;
				1: v = 32767;
				2: v = -1;
				3: v = 1;
				default: v = 0;
			endcase
		end else begin
			v = int'(lim_speed) + int'($urandom_range(0, 8)) - 4;
			if ($urandom_range(0, 1))
				v = -v;
		end
		return v[SPD_W-1:0];
	endfunction

	function automatic ddsl_pkg::kind_t pick_kind();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return ddsl_pkg::KIND_STRAIGHT;
		if (r < 14)
			return ddsl_pkg::KIND_TURN;
		if (r < 17)
			return ddsl_pkg::KIND_STOP;
		return ddsl_pkg::KIND_BAD;
	endfunction

	// ------------------------------------------------------------------
	// Result side: ready with random stalls, scoring, watchdog
	// ------------------------------------------------------------------

	task automatic report(string msg);
		mismatch_count++;
		$display("mismatch %0d at result %0d: %s", mismatch_count, result_count, msg);
	endtask

	task automatic check_field(string field, logic signed [31:0] got,
			logic signed [31:0] want);
		if (got !== want)
			report($sformatf("%s got %0d, expected %0d", field, got, want));
	endtask

	// Hold ready low for a drawn stall, raise it, keep it up until a beat lands.
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = sink_calm ? 0 : $urandom_range(0, 18);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (res_ch.valid !== 1'b1);
			@(negedge clk);
		end
	end

	// Score every result beat against the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			result_count++;
			if (pending_motor.size() == 0) begin
				report("result beat with nothing pending");
			end else begin
				head_res = pending_motor.pop_front();
				check_field("right_speed", res_ch.right_speed, head_res.right_speed);
				check_field("left_speed", res_ch.left_speed, head_res.left_speed);
				check_field("right_duty", res_ch.right_duty, head_res.right_duty);
				check_field("left_duty", res_ch.left_duty, head_res.left_duty);
				check_field("bridge_pins", res_ch.bridge_pins, head_res.pins);
				check_field("bad_command", res_ch.bad_command, head_res.bad);
			end
		end
	end

	// Watchdog: count cycles without a beat on either channel.
	always @(posedge clk) begin
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
				|| (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int mode;
		arst_n             <= 1'b0;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.kind        <= ddsl_pkg::KIND_STRAIGHT;
		cmd_ch.dir_right   <= 1'b0;
		cmd_ch.speed_right <= '0;
		cmd_ch.speed_left  <= '0;
		cfg_we             <= 1'b0;
		cfg_idx            <= ddsl_pkg::CFG_SPEED_LIMIT;
		cfg_data           <= '0;

		// Register defaults and zero speeds, as after reset.
		lim_speed   = 1600;
		lim_step    = 160;
		scale_speed = 3200;
		duty_full   = 100;
		right_now   = 0;
		left_now    = 0;

		// Directed table. The first rows start from reset, so their results are
		// plain: one step of 160 is duty 100*160/3200 = 5, and a zero speed gives
		// pins r2|l1.
		plan_known(ddsl_pkg::KIND_BAD, 1'b1, 32767, -32768, 0, 0, 0, 0, 4'b0110, 1);
		// Most negative left request: negated at full width, then clamped.
		plan_known(ddsl_pkg::KIND_STRAIGHT, 1'b1, 32767, -32768, 160, 160, 5, 5, 4'b0101, 0);
		plan_known(ddsl_pkg::KIND_STOP, 1'b0, -1, 1, 0, 0, 0, 0, 4'b0110, 0);
		plan_known(ddsl_pkg::KIND_TURN, 1'b1, 32767, -32768, -160, 160, 5, 5, 4'b0110, 0);
		plan_cmd(ddsl_pkg::KIND_STRAIGHT, 1'b0, -32768, 32767);
		plan_cmd(ddsl_pkg::KIND_TURN, 1'b0, 100, -100);
		plan_cmd(ddsl_pkg::KIND_STRAIGHT, 1'b1, -5, 5);
		// Widest step: a command lands on its clamped target in one go.
		plan_write(ddsl_pkg::CFG_STEP_LIMIT, 32767);
		plan_cmd(ddsl_pkg::KIND_STRAIGHT, 1'b1, 32767, 32767);
		// Widest speed range: duty saturates at duty_steps.
		plan_write(ddsl_pkg::CFG_SPEED_LIMIT, 32767);
		plan_cmd(ddsl_pkg::KIND_STRAIGHT, 1'b1, 32767, -32768);
		plan_cmd(ddsl_pkg::KIND_TURN, 1'b0, -32768, -32768);
		plan_cmd(ddsl_pkg::KIND_BAD, 1'b1, 0, 0);
		// Tiny full scale with the largest duty: any motion is full duty.
		plan_write(ddsl_pkg::CFG_DUTY_STEPS, 1023);
		plan_write(ddsl_pkg::CFG_FULL_SCALE, 1);
		plan_cmd(ddsl_pkg::KIND_STRAIGHT, 1'b1, 1, 0);
		plan_cmd(ddsl_pkg::KIND_TURN, 1'b1, -1, 1);
		// Zero full scale: the range check saturates the duty.
		plan_write(ddsl_pkg::CFG_FULL_SCALE, 0);
		plan_cmd(ddsl_pkg::KIND_STRAIGHT, 1'b1, 300, 0);
		plan_cmd(ddsl_pkg::KIND_STOP, 1'b1, 0, 0);
		// Smallest duty period with the largest full scale.
		plan_write(ddsl_pkg::CFG_DUTY_STEPS, 1);
		plan_write(ddsl_pkg::CFG_FULL_SCALE, 32767);
		plan_cmd(ddsl_pkg::KIND_STRAIGHT, 1'b1, 32767, -32767);
		// Zero speed limit: every target clamps to zero.
		plan_write(ddsl_pkg::CFG_SPEED_LIMIT, 0);
		plan_cmd(ddsl_pkg::KIND_STRAIGHT, 1'b0, 1234, -1234);
		plan_cmd(ddsl_pkg::KIND_TURN, 1'b1, 32767, 32767);
		// Zero step limit: speeds freeze.
		plan_write(ddsl_pkg::CFG_SPEED_LIMIT, 1600);
		plan_write(ddsl_pkg::CFG_STEP_LIMIT, 0);
		plan_cmd(ddsl_pkg::KIND_STRAIGHT, 1'b1, 500, 500);
		plan_cmd(ddsl_pkg::KIND_STOP, 1'b0, 0, 0);
		plan_write(ddsl_pkg::CFG_STEP_LIMIT, 160);
		plan_write(ddsl_pkg::CFG_FULL_SCALE, 3200);
		plan_write(ddsl_pkg::CFG_DUTY_STEPS, 100);
		plan_cmd(ddsl_pkg::KIND_STOP, 1'b0, 0, 0);
		plan_cmd(ddsl_pkg::KIND_TURN, 1'b0, -32768, 32767);

		repeat (RESET_CYC) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the table; register writes wait for the block to drain.
		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_cmd(plan[i].kind, plan[i].dir, plan[i].sr, plan[i].sl,
					plan[i].known, plan[i].want);
			end
		end

		// Random phases: fresh register set each phase, then a run of commands.
		// Pacing per phase mixes random gaps with stretches of full throughput.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_reg(ddsl_pkg::CFG_SPEED_LIMIT, pick_reg(0, 32767, 4000));
			write_reg(ddsl_pkg::CFG_STEP_LIMIT, pick_reg(0, 32767, 400));
			write_reg(ddsl_pkg::CFG_FULL_SCALE, pick_reg(1, 32767, 4000));
			write_reg(ddsl_pkg::CFG_DUTY_STEPS, pick_reg(1, 1023, 1023));
			mode = (ph == 0) ? 0 : $urandom_range(0, 3);
			feed_calm = (mode == 1 || mode == 3);
			sink_calm = (mode == 2 || mode == 3);
			repeat (PHASE_CMDS)
				send_cmd(pick_kind(), $urandom_range(0, 1), pick_speed(), pick_speed(),
					1'b0, blank_res);
		end

		// Drain, then give the pipeline its full latency before the verdict.
		settle();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && pending_motor.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
